@@ hdl/bba_pkg.sv @@
// bba_pkg: shared types and constants of the block bitmap allocator
// no dependencies; used by the controller, the top level, the checker and the testbench

package bba_pkg;

	localparam int NUM_BLOCKS_DEF    = 4096;
	localparam int MAP_WORD_BITS_DEF = 32;

	localparam int TOTAL_W  = 13;
	localparam int BLOCK_W  = 12;
	localparam int STATUS_W = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(4096);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 2'd0,
		STATUS_FULL         = 2'd1,
		STATUS_RANGE        = 2'd2,
		STATUS_ALREADY_FREE = 2'd3
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [BLOCK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] result_block;
		status_t            status;
		logic [TOTAL_W-1:0] free_count;
	} rsp_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_blocks;
	} cfg_t;

endpackage

@@ hdl/bba_chan_if.sv @@
// bba_chan_if: valid/ready channel carrying one payload beat of type T
// no dependencies; payload types come from bba_pkg at instantiation

interface bba_chan_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/bba_map_mem.sv @@
// bba_map_mem: occupancy map storage, one synchronous read and one write port
// per-row valid bits make unwritten rows read as all free; no package use

module bba_map_mem #(
	parameter int WORDS = 128,
	parameter int W     = 32,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data
);

	logic [W-1:0]     mem [WORDS];
	logic [W-1:0]     rdata_q;
	logic             rvalid_q;
	logic [WORDS-1:0] row_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// row valid bits, cleared at reset so the whole map reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (rd_en) begin
				rvalid_q <= row_valid_q[rd_addr];
			end
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

@@ hdl/bba_ctrl.sv @@
// bba_ctrl: request sequencer; scans map words, read-modify-writes one bit,
// keeps the used count and the result register. depends on bba_pkg

module bba_ctrl #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
	parameter int W          = bba_pkg::MAP_WORD_BITS_DEF,
	parameter int AW         = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  bba_pkg::req_t                req_data,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output bba_pkg::rsp_t                rsp_data,
	input  logic [bba_pkg::TOTAL_W-1:0]  total,
	output logic                         rd_en,
	output logic [AW-1:0]                rd_addr,
	input  logic [W-1:0]                 rd_data,
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic [W-1:0]                 wr_data
);

	localparam int WB = $clog2(W);
	localparam int TW = bba_pkg::TOTAL_W;
	localparam int BW = bba_pkg::BLOCK_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CHK  = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t             state_q;
	bba_pkg::op_t       op_q;
	logic [BW-1:0]      blk_q;
	logic [AW-1:0]      word_q;
	logic [TW-1:0]      used_q;
	bba_pkg::status_t   status_q;
	logic [BW-1:0]      result_q;
	logic               rsp_valid_q;
	bba_pkg::rsp_t      rsp_data_q;

	logic [TW-1:0]      eff;
	logic [TW-1:0]      eff_m1;
	logic [AW-1:0]      last_word;
	logic [WB-1:0]      lim;
	logic [AW-1:0]      req_word;
	logic               req_accept;
	logic               req_range;
	logic               hit;
	logic [WB-1:0]      hit_idx;
	logic [31:0]        alloc_n;
	logic [TW-1:0]      free_now;
	logic               blk_set;
	logic               out_load;

	// effective total saturates at the map size
	assign eff       = (32'(total) > NUM_BLOCKS) ? TW'(NUM_BLOCKS) : total;
	assign eff_m1    = eff - TW'(1);
	assign last_word = AW'(eff_m1 >> WB);
	assign lim       = eff_m1[WB-1:0];
	assign req_word  = AW'(req_data.block_number >> WB);
	assign req_range = {1'b0, req_data.block_number} >= eff;

	assign req_ready  = (state_q == S_IDLE);
	assign req_accept = req_valid && req_ready;
	assign blk_set    = rd_data[blk_q[WB-1:0]];
	assign free_now   = (eff > used_q) ? (eff - used_q) : '0;
	assign out_load   = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);
	assign alloc_n    = 32'({word_q, hit_idx});

	// lowest clear bit of the word that still lies below the total
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int b = W - 1; b >= 0; b--) begin
			if (!rd_data[b] && ((word_q != last_word) || (WB'(b) <= lim))) begin
				hit     = 1'b1;
				hit_idx = WB'(b);
			end
		end
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = rd_data;
		case (state_q)
			S_IDLE: begin
				rd_en   = req_accept;
				rd_addr = (req_data.op == bba_pkg::OP_FREE) ? req_word : '0;
			end
			S_CHK: begin
				if (op_q == bba_pkg::OP_FREE) begin
					wr_en   = blk_set;
					wr_data = rd_data & ~(W'(1) << blk_q[WB-1:0]);
				end else if (hit) begin
					wr_en   = 1'b1;
					wr_data = rd_data | (W'(1) << hit_idx);
				end else if (word_q != last_word) begin
					rd_en   = 1'b1;
					rd_addr = word_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						if (req_data.op == bba_pkg::OP_FREE) begin
							state_q <= req_range ? S_RESP : S_CHK;
						end else begin
							state_q <= (eff == '0) ? S_RESP : S_CHK;
						end
					end
				end
				S_CHK: begin
					if (op_q == bba_pkg::OP_FREE) begin
						state_q <= S_RESP;
						if (blk_set && used_q != '0) begin
							used_q <= used_q - TW'(1);
						end
					end else if (hit) begin
						state_q <= S_RESP;
						used_q  <= used_q + TW'(1);
					end else if (word_q == last_word) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload side
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					op_q     <= req_data.op;
					blk_q    <= req_data.block_number;
					word_q   <= (req_data.op == bba_pkg::OP_FREE) ? req_word : '0;
					result_q <= '0;
					status_q <= (req_data.op == bba_pkg::OP_FREE) ?
						bba_pkg::STATUS_RANGE : bba_pkg::STATUS_FULL;
				end
			end
			S_CHK: begin
				if (op_q == bba_pkg::OP_FREE) begin
					if (blk_set) begin
						status_q <= bba_pkg::STATUS_OK;
						result_q <= blk_q;
					end else begin
						status_q <= bba_pkg::STATUS_ALREADY_FREE;
					end
				end else if (hit) begin
					status_q <= bba_pkg::STATUS_OK;
					result_q <= alloc_n[BW-1:0];
				end else if (word_q != last_word) begin
					word_q <= word_q + AW'(1);
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			rsp_data_q.result_block <= result_q;
			rsp_data_q.status       <= status_q;
			rsp_data_q.free_count   <= free_now;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

@@ hdl/block_bitmap_allocator_top.sv @@
// block_bitmap_allocator_top: first-fit bitmap block allocator
// steps: free reads its map word, clears the bit if set and registers the result beat; out-of-range
//   or zero-total registers the result beat directly; allocate scans map words (at most MAP_WORDS, 128 by default)
// throughput: one item at a time, next item taken the cycle after the result is registered;
//   scan rate is one map word per cycle, set by the single map read port
// reset: map reads all free at once through row valid bits, no clearing pass; total 4096

module block_bitmap_allocator_top #(
	parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bba_chan_if.sink   req,
	bba_chan_if.source rsp,
	bba_chan_if.sink   cfg
);

	// map geometry
	localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	logic [bba_pkg::TOTAL_W-1:0] total_q;

	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [MAP_WORD_BITS-1:0] rd_data;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [MAP_WORD_BITS-1:0] wr_data;

	bba_pkg::req_t req_data;
	bba_pkg::rsp_t rsp_data;
	bba_pkg::cfg_t cfg_data;

	// config beats are always taken; the user must write only while the block is idle, the block does not enforce it
	assign cfg.ready = 1'b1;
	assign cfg_data  = cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bba_pkg::TOTAL_RESET;
		end else if (cfg.valid) begin
			total_q <= cfg_data.total_blocks;
		end
	end

	assign req_data = req.data;
	assign rsp.data = rsp_data;

	// sequencer: decode, word scan, bit update, result register
	bba_ctrl #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.W          (MAP_WORD_BITS),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req_data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data),
		.total     (total_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// occupancy map, one bit per block, bit 0 of each word holds the lowest block of that word
	bba_map_mem #(
		.WORDS (MAP_WORDS),
		.W     (MAP_WORD_BITS),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

@@ tb/allocation_checker.sv @@
`timescale 1ns / 100ps
// allocation_checker: watches the request, response and register channels of the allocator
// keeps its own occupancy map and used count, predicts every response and counts mismatches
// depends on bba_pkg

module allocation_checker
	import bba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_data,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  cfg_t cfg_data,
	output int   pending,
	output int   fail_count
);

	localparam int MAP_BITS = NUM_BLOCKS_DEF;

	bit [MAP_BITS-1:0]  occupied;
	int unsigned        used_blocks;
	logic [TOTAL_W-1:0] total_blocks;
	rsp_t               expected_rsp_q[$];

	function automatic int unsigned managed_blocks();
		return (total_blocks > MAP_BITS) ? MAP_BITS : total_blocks;
	endfunction

	// first fit from block 0 upward, frees refused out of range or when already clear
	function automatic rsp_t predict_allocation(req_t r);
		int unsigned span;
		int unsigned n;
		rsp_t        p;
		span = managed_blocks();
		p.result_block = '0;
		if (r.op == OP_ALLOC) begin
			n = 0;
			while (n < span && occupied[n])
				n++;
			if (n < span) begin
				occupied[n] = 1'b1;
				used_blocks++;
				p.result_block = BLOCK_W'(n);
				p.status = STATUS_OK;
			end else begin
				p.status = STATUS_FULL;
			end
		end else if (r.block_number >= span) begin
			p.status = STATUS_RANGE;
		end else if (!occupied[r.block_number]) begin
			p.status = STATUS_ALREADY_FREE;
		end else begin
			occupied[r.block_number] = 1'b0;
			if (used_blocks > 0)
				used_blocks--;
			p.result_block = r.block_number;
			p.status = STATUS_OK;
		end
		p.free_count = (used_blocks >= span) ? '0 : TOTAL_W'(span - used_blocks);
		return p;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			occupied = '0;
			used_blocks = 0;
			total_blocks = TOTAL_RESET;
			expected_rsp_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				total_blocks = cfg_data.total_blocks;
			if (req_valid && req_ready)
				expected_rsp_q.push_back(predict_allocation(req_data));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch($sformatf("response beat with nothing outstanding, block %0d",
						rsp_data.result_block));
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp_data.result_block !== want.result_block)
						report_mismatch($sformatf("result_block got %0d expected %0d",
							rsp_data.result_block, want.result_block));
					if (rsp_data.status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							rsp_data.status, want.status));
					if (rsp_data.free_count !== want.free_count)
						report_mismatch($sformatf("free_count got %0d expected %0d",
							rsp_data.free_count, want.free_count));
				end
			end
			pending <= expected_rsp_q.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// testbench: stimulus and verdict for block_bitmap_allocator_top
// depends on bba_pkg, bba_chan_if, the allocator top level and allocation_checker

module testbench;

	import bba_pkg::*;

	// nothing accepted for this long means the block is hung
	localparam int IDLE_LIMIT    = 4000;
	// longest allocate scan covers 128 map words, leave room for a stray late beat
	localparam int DRAIN_CYCLES  = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 66;

	logic clk;
	logic arst_n = 1'b0;

	// when set both sides run back to back with no idle cycles
	bit steady_flow = 1'b0;
	// register value last written, used to aim frees near the managed range
	logic [TOTAL_W-1:0] current_total = TOTAL_RESET;

	int pending;
	int fail_count;

	bba_chan_if #(.T(req_t)) req_if ();
	bba_chan_if #(.T(rsp_t)) rsp_if ();
	bba_chan_if #(.T(cfg_t)) cfg_if ();

	block_bitmap_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	allocation_checker alloc_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_if.valid),
		.req_ready  (req_if.ready),
		.req_data   (req_if.data),
		.rsp_valid  (rsp_if.valid),
		.rsp_ready  (rsp_if.ready),
		.rsp_data   (rsp_if.data),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_data   (cfg_if.data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// idle cycles before a beat: none in steady stretches, otherwise often none
	// and else a uniform random draw, which may itself be none
	function automatic int draw_gap();
		if (steady_flow || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// free target: mostly within or just past the managed range so frees hit
	// allocated blocks, already free blocks and the range check, sometimes anywhere
	function automatic logic [BLOCK_W-1:0] pick_block();
		int unsigned hi;
		if ($urandom_range(0, 9) < 2)
			return BLOCK_W'($urandom_range(0, 4095));
		hi = (current_total > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : current_total;
		hi = hi + 3;
		if (hi > 4095)
			hi = 4095;
		return BLOCK_W'($urandom_range(0, hi));
	endfunction

	// one request beat; valid stays high across back-to-back beats
	task automatic send_request(op_t op, logic [BLOCK_W-1:0] blk);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data.op <= op;
		req_if.data.block_number <= blk;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// allocate with a random don't-care block number
	task automatic allocate();
		send_request(OP_ALLOC, BLOCK_W'($urandom()));
	endtask

	// drop valid and wait until every response beat has come back
	task automatic wait_for_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// register writes only ever happen with the block idle
	task automatic write_total(logic [TOTAL_W-1:0] value);
		wait_for_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.data.total_blocks <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		current_total = value;
	endtask

	// register setting of each random phase: extremes mixed with ordinary sizes
	function automatic logic [TOTAL_W-1:0] phase_total(int phase);
		case (phase)
			0:       return TOTAL_W'(37);
			1:       return TOTAL_W'(4096);
			2:       return TOTAL_W'(1);
			3:       return TOTAL_W'($urandom_range(100, 300));
			4:       return TOTAL_W'(8191);
			5:       return TOTAL_W'(64);
			6:       return TOTAL_W'(0);
			default: return TOTAL_W'(4095);
		endcase
	endfunction

	// response side: random stalls per beat, ready held until the beat is taken
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	// watchdog: any handshake on any channel counts as progress
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int alloc_pct;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty map at the reset total: frees of clear blocks at both ends
		send_request(OP_FREE, BLOCK_W'(0));
		send_request(OP_FREE, BLOCK_W'(4095));
		allocate();
		allocate();
		send_request(OP_ALLOC, 12'hFFF);
		// free a middle block and see first fit take it back
		send_request(OP_FREE, BLOCK_W'(1));
		allocate();

		// zero total manages nothing: allocate is full, any free out of range
		write_total(TOTAL_W'(0));
		allocate();
		send_request(OP_FREE, BLOCK_W'(0));

		// largest register value saturates at the map size
		write_total(TOTAL_W'(8191));
		allocate();
		send_request(OP_FREE, BLOCK_W'(4095));
		send_request(OP_FREE, BLOCK_W'(3));

		// total equal to the used blocks: map full
		write_total(TOTAL_W'(3));
		allocate();

		// total lowered below the used blocks: block 2 stranded, free count pinned at 0
		write_total(TOTAL_W'(2));
		send_request(OP_FREE, BLOCK_W'(2));
		allocate();
		send_request(OP_FREE, BLOCK_W'(0));
		allocate();

		// smallest nonzero total
		write_total(TOTAL_W'(1));
		send_request(OP_FREE, BLOCK_W'(1));
		send_request(OP_FREE, BLOCK_W'(0));
		allocate();

		// back to the full map: stranded block freeable again, alternating bit patterns
		write_total(TOTAL_W'(4096));
		send_request(OP_FREE, BLOCK_W'(2));
		allocate();
		send_request(OP_FREE, 12'hAAA);
		send_request(OP_FREE, 12'h555);
		send_request(OP_FREE, BLOCK_W'(2048));

		// random phases: each picks a total and an allocate share, map carries over
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_total(phase_total(phase));
			alloc_pct = $urandom_range(35, 70);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// every dozen beats decide whether this stretch runs without idling
				if (i % 12 == 0)
					steady_flow = ($urandom_range(0, 2) == 0);
				if ($urandom_range(0, 99) < alloc_pct)
					allocate();
				else
					send_request(OP_FREE, pick_block());
			end
			steady_flow = 1'b0;
		end

		wait_for_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/bba_pkg.sv
hdl/bba_chan_if.sv
hdl/bba_map_mem.sv
hdl/bba_ctrl.sv
hdl/block_bitmap_allocator_top.sv
tb/allocation_checker.sv
tb/testbench.sv
